/* design/fdpa_pkg.sv */
// Shared types and constants for the fixed-point decimal to ASCII formatter.
`default_nettype none

package fdpa_pkg;

    localparam int unsigned TextLen = 6;
    localparam int unsigned SlotW   = $clog2(TextLen);

    typedef logic [7:0] char_t;
    typedef logic [TextLen-1:0][7:0] text_t;
    typedef logic [SlotW-1:0] slot_t;

    // Formatted text, right-aligned in its slots, with the first slot to send.
    typedef struct packed {
        text_t text;
        slot_t start;
    } fmt_t;

    localparam slot_t LAST_SLOT = slot_t'(TextLen - 1);

    localparam logic signed [31:0] LOW_LIMIT  = -32'sd9999;
    localparam logic signed [31:0] HIGH_LIMIT = 32'sd9999;

    // Reciprocals: floor(mag * R >> S) equals mag / D for every mag up to 9999.
    localparam logic [26:0] RECIP_10   = 27'd6554;
    localparam logic [26:0] RECIP_100  = 27'd5243;
    localparam logic [26:0] RECIP_1000 = 27'd8389;

    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_POINT = 8'h2E;
    localparam char_t CHAR_STAR  = 8'h2A;

endpackage

`default_nettype wire

/* design/fdpa_if.sv */
// Valid/ready channel interfaces for the number input and the character output.
`default_nettype none

interface fdpa_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fdpa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* design/fdpa_format.sv */
// Range check, digit split and character layout for one number.
`default_nettype none

module fdpa_format (
    input  wire logic [31:0]     value,
    output fdpa_pkg::fmt_t       fmt
);

    logic        neg;
    logic        too_low;
    logic        too_high;
    logic [13:0] mag;
    logic [26:0] p10;
    logic [26:0] p100;
    logic [26:0] p1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;

    assign neg      = value[31];
    assign too_low  = $signed(value) < fdpa_pkg::LOW_LIMIT;
    assign too_high = $signed(value) > fdpa_pkg::HIGH_LIMIT;

    // In range the magnitude fits in 14 bits, so negate only the low bits.
    assign mag = neg ? 14'(~value[13:0] + 14'd1) : value[13:0];

    assign p10   = 27'(mag) * fdpa_pkg::RECIP_10;
    assign p100  = 27'(mag) * fdpa_pkg::RECIP_100;
    assign p1000 = 27'(mag) * fdpa_pkg::RECIP_1000;

    assign q10   = p10[25:16];
    assign q100  = p100[25:19];
    assign q1000 = p1000[26:23];

    assign d0 = 4'(mag - 14'(q10) * 14'd10);
    assign d1 = 4'(q10 - 10'(q100) * 10'd10);
    assign d2 = 4'(q100 - 7'(q1000) * 7'd10);
    assign d3 = q1000;

    always_comb
    begin
        fmt.text[5] = fdpa_pkg::CHAR_ZERO + {4'b0, d0};
        fmt.text[4] = fdpa_pkg::CHAR_ZERO + {4'b0, d1};
        fmt.text[3] = fdpa_pkg::CHAR_POINT;
        fmt.text[2] = fdpa_pkg::CHAR_ZERO + {4'b0, d2};
        fmt.text[1] = fdpa_pkg::CHAR_ZERO + {4'b0, d3};
        fmt.text[0] = fdpa_pkg::CHAR_MINUS;
        fmt.start   = 3'd0;
        if (too_low || too_high)
        begin
            fmt.text[5] = fdpa_pkg::CHAR_STAR;
            fmt.text[4] = fdpa_pkg::CHAR_STAR;
            fmt.text[2] = fdpa_pkg::CHAR_STAR;
            fmt.text[1] = fdpa_pkg::CHAR_STAR;
            fmt.text[0] = too_low ? fdpa_pkg::CHAR_MINUS : fdpa_pkg::CHAR_SPACE;
        end
        else if (d3 != 4'd0)
        begin
            fmt.start = neg ? 3'd0 : 3'd1;
        end
        else
        begin
            // Drop the leading zero: the sign moves into the tens slot.
            fmt.text[1] = fdpa_pkg::CHAR_MINUS;
            fmt.start   = neg ? 3'd1 : 3'd2;
        end
    end

endmodule

`default_nettype wire

/* design/fdpa_serial.sv */
// Output register that sends the formatted text one character per beat.
`default_nettype none

module fdpa_serial (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire fdpa_pkg::fmt_t  fmt,
    output logic                 free,
    fdpa_out_if.source           text
);

    logic                valid_reg;
    logic                valid_next;
    fdpa_pkg::slot_t     idx_reg;
    fdpa_pkg::slot_t     idx_next;
    fdpa_pkg::text_t     text_reg;
    fdpa_pkg::text_t     text_next;
    logic                last;

    assign last           = idx_reg == fdpa_pkg::LAST_SLOT;
    assign free           = !valid_reg || (text.ready && last);
    assign text.valid     = valid_reg;
    assign text.char_code = text_reg[idx_reg];
    assign text.last_char = last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        text_next  = text_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = fmt.start;
            text_next  = fmt.text;
        end
        else if (valid_reg && text.ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg <= text_next;
    end

endmodule

`default_nettype wire

/* design/decimal_fixed_point_to_ascii.sv */
// Flow: an accepted number waits in the input register, is formatted combinationally,
// and is loaded into the character output register once that register is free.
// Throughput: one character per cycle while text.ready is high; the character output
// register sets the pace, and the input register takes the next number while the current
// text is still going out. Reset: rst_n clears both valid flags and the index at once.
`default_nettype none

module decimal_fixed_point_to_ascii (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fdpa_in_if.sink     num,
    fdpa_out_if.source  text
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [31:0]        value_reg;
    logic               free;
    logic               load;
    logic               take;
    fdpa_pkg::fmt_t     fmt;

    assign load      = in_valid_reg && free;
    assign num.ready = !in_valid_reg || free;
    assign take      = num.valid && num.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the number until the output side frees up.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= num.value;
        end
    end

    fdpa_format u_format (
        .value (value_reg),
        .fmt   (fmt)
    );

    fdpa_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .fmt   (fmt),
        .free  (free),
        .text  (text)
    );

endmodule

`default_nettype wire

/* tb/sv/fdpa_text_scoreboard.sv */
// Scoreboard that predicts the ASCII text of every accepted number and checks each character beat.
module fdpa_text_scoreboard (
    input  logic clk,
    input  logic rst_n,
    fdpa_in_if   num,
    fdpa_out_if  text,
    output int   fail_count,
    output int   chars_pending
);

    typedef struct packed {
        fdpa_pkg::char_t code;
        logic            last;
    } text_beat_t;

    text_beat_t expected_text[$];
    int         fails = 0;
    int         pending_count = 0;

    assign fail_count    = fails;
    assign chars_pending = pending_count;

    function automatic void note_failure(input string msg);
        fails++;
        if (fails <= 10)
            $display("[%0t] text check: %s", $time, msg);
    endfunction

    // Format one number into its character beats and queue them.
    function automatic void queue_number_text(input logic signed [31:0] value);
        fdpa_pkg::char_t chars[$];
        int              signed_val;
        int unsigned     mag;
        int unsigned     whole;
        text_beat_t      beat;
        signed_val = value;
        if (value < fdpa_pkg::LOW_LIMIT || value > fdpa_pkg::HIGH_LIMIT) begin
            chars.push_back((value < fdpa_pkg::LOW_LIMIT) ? fdpa_pkg::CHAR_MINUS
                                                          : fdpa_pkg::CHAR_SPACE);
            chars.push_back(fdpa_pkg::CHAR_STAR);
            chars.push_back(fdpa_pkg::CHAR_STAR);
            chars.push_back(fdpa_pkg::CHAR_POINT);
            chars.push_back(fdpa_pkg::CHAR_STAR);
            chars.push_back(fdpa_pkg::CHAR_STAR);
        end
        else begin
            if (signed_val < 0) begin
                chars.push_back(fdpa_pkg::CHAR_MINUS);
                mag = -signed_val;
            end
            else begin
                mag = signed_val;
            end
            whole = mag / 100;
            // Drop the leading zero of the integer part.
            if (whole >= 10)
                chars.push_back(fdpa_pkg::CHAR_ZERO + fdpa_pkg::char_t'(whole / 10));
            chars.push_back(fdpa_pkg::CHAR_ZERO + fdpa_pkg::char_t'(whole % 10));
            chars.push_back(fdpa_pkg::CHAR_POINT);
            chars.push_back(fdpa_pkg::CHAR_ZERO + fdpa_pkg::char_t'((mag / 10) % 10));
            chars.push_back(fdpa_pkg::CHAR_ZERO + fdpa_pkg::char_t'(mag % 10));
        end
        foreach (chars[i]) begin
            beat.code = chars[i];
            beat.last = (i == chars.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    always @(posedge clk) begin
        text_beat_t want;
        if (rst_n === 1'b1) begin
            if (text.valid && text.ready) begin
                if (expected_text.size() == 0) begin
                    note_failure($sformatf("unexpected beat char %h last %b",
                                           text.char_code, text.last_char));
                end
                else begin
                    want = expected_text.pop_front();
                    if (text.char_code !== want.code)
                        note_failure($sformatf("char_code expected %h got %h",
                                               want.code, text.char_code));
                    if (text.last_char !== want.last)
                        note_failure($sformatf("last_char expected %b got %b (char %h)",
                                               want.last, text.last_char, want.code));
                end
            end
            if (num.valid && num.ready)
                queue_number_text(num.value);
            pending_count = expected_text.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the formatter testbench: clock, reset, number stimulus, text back-pressure, verdict.
module testbench;

    localparam int RandomItems = 290;
    localparam int LongHold    = 300;
    localparam int StallLimit  = 3000;
    localparam int DrainCycles = 10;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   chars_pending;
    int   idle_cycles = 0;
    logic long_hold = 1'b0;
    logic hold_done = 1'b0;
    logic calm = 1'b0;

    fdpa_in_if  num_if ();
    fdpa_out_if text_if ();

    decimal_fixed_point_to_ascii u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .text  (text_if)
    );

    fdpa_text_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .num           (num_if),
        .text          (text_if),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold the number until the block takes it; return at the next falling edge.
    task automatic offer_number(input logic [31:0] value);
        num_if.valid <= 1'b1;
        num_if.value <= value;
        do
            @(posedge clk);
        while (!num_if.ready);
        @(negedge clk);
    endtask

    task automatic sender_gap(input int cycles);
        num_if.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pick_value = $urandom_range(0, 19998) - 9999;
            6:                pick_value = $urandom_range(0, 398) - 199;
            7:                pick_value = ($urandom_range(0, 1) ? 1 : -1) *
                                           int'($urandom_range(9985, 10015));
            default:          pick_value = $urandom();
        endcase
    endfunction

    // Number stimulus.
    initial
    begin
        logic [31:0] corner_values[$];
        corner_values = {32'h8000_0000, 32'h7FFF_FFFF, -32'sd10000, -32'sd9999, -32'sd9998,
                         -32'sd1000, -32'sd999, -32'sd100, -32'sd99, -32'sd10, -32'sd5,
                         -32'sd1, 32'sd0, 32'sd1, 32'sd5, 32'sd99, 32'sd100, 32'sd999,
                         32'sd1000, 32'sd1234, 32'sd9999, 32'sd10000, 32'h5555_5555,
                         32'hAAAA_AAAA};
        rst_n = 1'b0;
        num_if.valid = 1'b0;
        num_if.value = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_values[i]) begin
            if ($urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 12));
            offer_number(corner_values[i]);
        end

        for (int n = 0; n < RandomItems; n++) begin
            // Stall the text side for a long stretch while numbers keep coming.
            if (n == 60)
                long_hold = 1'b1;
            // Pause until every queued character has come out.
            if (n == 150) begin
                sender_gap(1);
                while (chars_pending != 0) @(negedge clk);
            end
            if (n == 240)
                calm = 1'b1;
            if (!calm && !(long_hold && !hold_done) && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 12));
            offer_number(pick_value());
        end

        sender_gap(1);
        while (chars_pending != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        if (fail_count == 0 && chars_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Text back-pressure.
    initial
    begin
        text_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (long_hold && !hold_done) begin
                text_if.ready <= 1'b0;
                repeat (LongHold) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0) begin
                text_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else begin
                text_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if ((num_if.valid && num_if.ready) || (text_if.valid && text_if.ready))
                idle_cycles <= 0;
            else if (idle_cycles == StallLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
